>>> sv/fsg_pkg.sv
// Shared types and constants for the falling-sand grid engine.
// No dependencies; compiled first.
package fsg_pkg;

    localparam int FLD_W  = 6;
    localparam int KIND_W = 2;

    typedef logic [1:0]        t_cell;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [FLD_W-1:0]  t_coord;

    localparam t_cell CELL_EMPTY   = 2'd0;
    localparam t_cell CELL_WALL    = 2'd1;
    localparam t_cell CELL_SAND    = 2'd2;
    localparam t_cell CELL_ILLEGAL = 2'd3;

    localparam t_kind KIND_STEP  = 2'd0;
    localparam t_kind KIND_PAINT = 2'd1;
    localparam t_kind KIND_READ  = 2'd2;
    localparam t_kind KIND_NOP   = 2'd3;

    // datapath operation codes
    typedef logic [2:0] t_op;
    localparam t_op OP_IDLE  = 3'd0;
    localparam t_op OP_CLEAR = 3'd1;
    localparam t_op OP_STEP  = 3'd2;
    localparam t_op OP_PAINT = 3'd3;
    localparam t_op OP_READ  = 3'd4;
    localparam t_op OP_NOP   = 3'd5;

    typedef struct packed {
        logic   start;
        t_op    op;
        t_coord row;
        t_coord col;
        t_cell  paint_type;
    } t_cmd;

    typedef struct packed {
        logic  done;
        t_cell rd_cell;
    } t_sts;

endpackage

>>> sv/fsg_if.sv
// Valid/ready channel interfaces for item and result beats.
// Depends on fsg_pkg.
interface fsg_in_if import fsg_pkg::*; ();
    logic   valid;
    logic   ready;
    t_kind  kind;
    t_coord row;
    t_coord col;

    modport source (output valid, output kind, output row, output col, input ready);
    modport sink   (input valid, input kind, input row, input col, output ready);
endinterface

interface fsg_out_if import fsg_pkg::*; ();
    logic  valid;
    logic  ready;
    t_cell cell_type;
    t_kind done_kind;

    modport source (output valid, output cell_type, output done_kind, input ready);
    modport sink   (input valid, input cell_type, input done_kind, output ready);
endinterface

>>> sv/fsg_ctrl.sv
// Controller: sequencing FSM, paint_type register and result register.
// Depends on fsg_pkg.
module fsg_ctrl import fsg_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_kind  i_in_kind,
    input  t_coord i_in_row,
    input  t_coord i_in_col,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_cell  o_out_cell,
    output t_kind  o_out_kind,
    input  logic   i_cfg_wr_en,
    input  t_cell  i_cfg_wr_data,
    output t_cmd   o_cmd,
    input  t_sts   i_sts
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_IDLE  = 3'd2;
    localparam logic [2:0] ST_BUSY  = 3'd3;
    localparam logic [2:0] ST_HOLD  = 3'd4;

    logic [2:0] r_state, n_state;
    t_cell      r_paint_type;
    t_kind      r_kind;
    t_cell      r_res;
    logic       r_out_vld;
    t_cell      r_out_cell;
    t_kind      r_out_kind;

    logic  accept;
    logic  out_free;
    logic  load_out;
    t_cell res_cell;
    t_op   op_sel;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_vld || i_out_ready;

    always_comb begin
        case (i_in_kind)
            KIND_STEP:  op_sel = OP_STEP;
            KIND_PAINT: op_sel = OP_PAINT;
            KIND_READ:  op_sel = OP_READ;
            default:    op_sel = OP_NOP;
        endcase
    end

    always_comb begin
        o_cmd.start      = accept || (r_state == ST_INIT);
        o_cmd.op         = (r_state == ST_INIT) ? OP_CLEAR : op_sel;
        o_cmd.row        = i_in_row;
        o_cmd.col        = i_in_col;
        o_cmd.paint_type = r_paint_type;
    end

    // result cell is only meaningful for reads
    assign res_cell = (r_state == ST_HOLD) ? r_res :
                      ((r_kind == KIND_READ) ? i_sts.rd_cell : CELL_EMPTY);

    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        case (r_state)
            ST_INIT:  n_state = ST_CLEAR;
            ST_CLEAR: if (i_sts.done) begin
                n_state = ST_IDLE;
            end
            ST_IDLE:  if (accept) begin
                n_state = ST_BUSY;
            end
            ST_BUSY:  if (i_sts.done) begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD:  if (out_free) begin
                load_out = 1'b1;
                n_state  = ST_IDLE;
            end
            default:  n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_paint_type <= CELL_SAND;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_paint_type <= i_cfg_wr_data;
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_in_kind;
        end
        if (r_state == ST_BUSY && i_sts.done) begin
            r_res <= res_cell;
        end
        if (load_out) begin
            r_out_cell <= res_cell;
            r_out_kind <= r_kind;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_cell  = r_out_cell;
    assign o_out_kind  = r_out_kind;

endmodule

>>> sv/fsg_dp.sv
// Datapath: grid memory, raster-scan window for steps, disc walker for paint/read.
// Depends on fsg_pkg.
module fsg_dp import fsg_pkg::*; #(
    parameter int GRID_ROWS    = 64,
    parameter int GRID_COLS    = 64,
    parameter int BRUSH_RADIUS = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_sts o_sts
);

    localparam int CELLS  = GRID_ROWS * GRID_COLS;
    localparam int AW     = $clog2(CELLS);
    localparam int RBW    = $clog2(GRID_ROWS);
    localparam int CBW    = $clog2(GRID_COLS);
    localparam int S_LAST = CELLS + GRID_COLS;
    localparam int SW     = $clog2(S_LAST + 1);
    localparam int WL     = 2 * GRID_COLS + 3;
    localparam int OFW    = $clog2(BRUSH_RADIUS + 1) + 1;
    localparam int DW     = 2 * OFW + 1;
    localparam int PWM    = (RBW > CBW) ? RBW : CBW;
    localparam int PW     = ((PWM > FLD_W) ? PWM : FLD_W) + 2;
    localparam int RR     = BRUSH_RADIUS * BRUSH_RADIUS;

    // window taps, newest beat at index 0
    localparam int T_DR  = 0;               // row+1, col+1
    localparam int T_D   = 1;
    localparam int T_DL  = 2;
    localparam int T_R   = GRID_COLS;
    localparam int T_C   = GRID_COLS + 1;
    localparam int T_L   = GRID_COLS + 2;
    localparam int T_LL  = GRID_COLS + 3;
    localparam int T_UR  = 2 * GRID_COLS;
    localparam int T_U   = 2 * GRID_COLS + 1;
    localparam int T_UL  = 2 * GRID_COLS + 2;

    t_cell mem [CELLS];
    t_cell r_mem_q;
    t_cell r_win [WL];

    t_op                  r_mode;
    logic                 r_s0;
    logic                 r_p1_vld, r_p1_last, r_p2_vld, r_fin;
    logic [SW-1:0]        r_scan, r_p1_idx;
    logic [AW-1:0]        r_oaddr, r_p1_addr;
    logic [RBW-1:0]       r_orow;
    logic [CBW-1:0]       r_ocol;
    logic signed [OFW-1:0] r_di, r_dj;
    t_coord               r_row, r_col;
    t_cell                r_ptype;
    t_cell                r_cell;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    t_cell         wr_data;

    // neighborhood
    logic v_up, v_dn, v_l, v_ll, v_r;
    logic e_d, e_dl, e_dr, e_r, e_l, e_ll;
    logic s_u, s_ur, s_ul, incoming;
    t_cell step_val, clr_val;
    logic last_cell, adv;

    // disc walker
    logic signed [PW-1:0] pr, pc;
    logic signed [DW-1:0] di_x, dj_x, dsq;
    logic                 p_in, p_last;
    logic [AW-1:0]        p_addr;

    assign v_up = (r_orow != '0);
    assign v_dn = (r_orow != RBW'(GRID_ROWS - 1));
    assign v_l  = (r_ocol != '0);
    assign v_ll = (r_ocol > CBW'(1));
    assign v_r  = (r_ocol != CBW'(GRID_COLS - 1));

    assign e_d  = v_dn && (r_win[T_D] == CELL_EMPTY);
    assign e_dl = v_dn && v_l && (r_win[T_DL] == CELL_EMPTY);
    assign e_dr = v_dn && v_r && (r_win[T_DR] == CELL_EMPTY);
    assign e_r  = v_r && (r_win[T_R] == CELL_EMPTY);
    assign e_l  = v_l && (r_win[T_L] == CELL_EMPTY);
    assign e_ll = v_ll && (r_win[T_LL] == CELL_EMPTY);
    assign s_u  = v_up && (r_win[T_U] == CELL_SAND);
    assign s_ur = v_up && v_r && (r_win[T_UR] == CELL_SAND);
    assign s_ul = v_up && v_l && (r_win[T_UL] == CELL_SAND);

    // grains from above, above-right (falls left) and above-left (falls right)
    assign incoming = s_u || (s_ur && !e_r) || (s_ul && !e_l && !e_ll);

    always_comb begin
        case (r_win[T_C])
            CELL_WALL: step_val = CELL_WALL;
            CELL_SAND: step_val = (!e_d && !e_dl && !e_dr) ? CELL_SAND : CELL_EMPTY;
            default:   step_val = incoming ? CELL_SAND : CELL_EMPTY;
        endcase
    end

    assign clr_val = (!v_up || !v_dn || !v_l || !v_r) ? CELL_WALL : CELL_EMPTY;

    assign last_cell = (r_orow == RBW'(GRID_ROWS - 1)) && (r_ocol == CBW'(GRID_COLS - 1));
    assign adv       = ((r_mode == OP_STEP) && r_p2_vld) || ((r_mode == OP_CLEAR) && r_s0);

    assign pr   = $signed({{(PW - FLD_W){1'b0}}, r_row}) + PW'(r_di);
    assign pc   = $signed({{(PW - FLD_W){1'b0}}, r_col}) + PW'(r_dj);
    assign di_x = DW'(r_di);
    assign dj_x = DW'(r_dj);
    assign dsq  = di_x * di_x + dj_x * dj_x;
    assign p_in = (pr >= 0) && (pr < $signed(PW'(GRID_ROWS))) &&
                  (pc >= 0) && (pc < $signed(PW'(GRID_COLS))) &&
                  (dsq <= $signed(DW'(RR)));
    assign p_addr = AW'(pr[RBW-1:0]) * AW'(GRID_COLS) + AW'(pc[CBW-1:0]);
    assign p_last = (r_mode == OP_READ) ||
                    ((r_di == $signed(OFW'(BRUSH_RADIUS))) &&
                     (r_dj == $signed(OFW'(BRUSH_RADIUS))));

    // single write port, single read port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_oaddr;
        wr_data = step_val;
        rd_addr = r_scan[AW-1:0];
        case (r_mode)
            OP_CLEAR: begin
                wr_en   = r_s0;
                wr_data = clr_val;
            end
            OP_STEP:  wr_en = r_p2_vld;
            OP_PAINT: begin
                rd_addr = p_addr;
                wr_addr = r_p1_addr;
                wr_data = r_ptype;
                wr_en   = r_p1_vld && (r_mem_q != CELL_WALL) && (r_ptype <= CELL_SAND);
            end
            OP_READ:  rd_addr = p_addr;
            default:  wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_mem_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= OP_IDLE;
            r_s0      <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_p1_last <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_fin     <= 1'b0;
        end else if (i_cmd.start) begin
            r_mode    <= i_cmd.op;
            r_s0      <= (i_cmd.op != OP_NOP);
            r_p1_vld  <= 1'b0;
            r_p1_last <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_fin     <= (i_cmd.op == OP_NOP);
        end else if (r_fin) begin
            r_mode <= OP_IDLE;
            r_fin  <= 1'b0;
        end else begin
            case (r_mode)
                OP_CLEAR: if (r_s0 && last_cell) begin
                    r_s0  <= 1'b0;
                    r_fin <= 1'b1;
                end
                OP_STEP: begin
                    r_p1_vld <= r_s0;
                    r_p2_vld <= r_p1_vld && (r_p1_idx >= SW'(GRID_COLS + 1));
                    if (r_scan == SW'(S_LAST)) begin
                        r_s0 <= 1'b0;
                    end
                    if (r_p2_vld && last_cell) begin
                        r_fin <= 1'b1;
                    end
                end
                OP_PAINT, OP_READ: begin
                    r_p1_vld  <= r_s0 && p_in;
                    r_p1_last <= r_s0 && p_last;
                    r_fin     <= r_p1_last;
                    if (p_last) begin
                        r_s0 <= 1'b0;
                    end
                end
                default: r_s0 <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_scan  <= '0;
            r_oaddr <= '0;
            r_orow  <= '0;
            r_ocol  <= '0;
            r_row   <= i_cmd.row;
            r_col   <= i_cmd.col;
            r_ptype <= i_cmd.paint_type;
            r_cell  <= CELL_EMPTY;
            r_di    <= (i_cmd.op == OP_PAINT) ? -$signed(OFW'(BRUSH_RADIUS)) : '0;
            r_dj    <= (i_cmd.op == OP_PAINT) ? -$signed(OFW'(BRUSH_RADIUS)) : '0;
        end else begin
            if (r_s0) begin
                r_scan <= r_scan + 1'b1;
            end
            r_p1_idx  <= r_scan;
            r_p1_addr <= p_addr;
            if (r_s0 && !p_last) begin
                if (r_dj == $signed(OFW'(BRUSH_RADIUS))) begin
                    r_dj <= -$signed(OFW'(BRUSH_RADIUS));
                    r_di <= r_di + 1'b1;
                end else begin
                    r_dj <= r_dj + 1'b1;
                end
            end
            if ((r_mode == OP_STEP) && r_p1_vld) begin
                r_win[0] <= (r_p1_idx >= SW'(CELLS)) ? CELL_WALL : r_mem_q;
                for (int k = 1; k < WL; k++) begin
                    r_win[k] <= r_win[k-1];
                end
            end
            if (adv) begin
                r_oaddr <= r_oaddr + 1'b1;
                if (r_ocol == CBW'(GRID_COLS - 1)) begin
                    r_ocol <= '0;
                    r_orow <= r_orow + 1'b1;
                end else begin
                    r_ocol <= r_ocol + 1'b1;
                end
            end
            if ((r_mode == OP_READ) && r_p1_last) begin
                r_cell <= r_p1_vld ? r_mem_q : CELL_EMPTY;
            end
        end
    end

    assign o_sts.done    = r_fin;
    assign o_sts.rd_cell = r_cell;

endmodule

>>> sv/falling_sand_grid_engine_unit.sv
// Top level of the falling-sand grid engine: controller plus datapath.
// Depends on fsg_pkg, fsg_if, fsg_ctrl, fsg_dp.
//
// Channels: i_in takes item beats (kind, row, col), o_out gives one result
// beat (cell_type, done_kind) per item. A beat moves when valid and ready are
// both high. i_cfg_wr_en/i_cfg_wr_data write paint_type (reset value sand).
//
// Work per item:
//   step  : one raster scan of the grid memory, one cell per cycle through its
//           single read port, results written back in place GRID_COLS + 3
//           cells behind the read pointer.
//   paint : one disc position per cycle.
//   read  : a single position.  kind 3: no change.
// One item is in work at a time; i_in.ready is high only when idle.
//
// Reset: synchronous, active low. After reset the block sweeps the grid
// memory, one cell per cycle, writing border walls and empty interior; no
// item is accepted meanwhile.
//
// Stall: the result sits in an output register. If o_out is stalled when the
// next result finishes, it is parked and the block stops taking items until
// the receiver drains it.
module falling_sand_grid_engine_unit import fsg_pkg::*; #(
    parameter int GRID_ROWS    = 64,
    parameter int GRID_COLS    = 64,
    parameter int BRUSH_RADIUS = 5
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fsg_in_if.sink       i_in,
    fsg_out_if.source    o_out,
    input  logic         i_cfg_wr_en,
    input  t_cell        i_cfg_wr_data
);

    t_cmd cmd;
    t_sts sts;

    fsg_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .o_in_ready    (i_in.ready),
        .i_in_kind     (i_in.kind),
        .i_in_row      (i_in.row),
        .i_in_col      (i_in.col),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_out_cell    (o_out.cell_type),
        .o_out_kind    (o_out.done_kind),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cmd         (cmd),
        .i_sts         (sts)
    );

    fsg_dp #(
        .GRID_ROWS    (GRID_ROWS),
        .GRID_COLS    (GRID_COLS),
        .BRUSH_RADIUS (BRUSH_RADIUS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

>>> sv/fsg_checker.sv
// Port-level checks for the falling-sand grid engine, bound to the top level.
// Depends on fsg_pkg and falling_sand_grid_engine_unit.
module fsg_checker import fsg_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_cell i_out_cell,
    input t_kind i_out_kind
);

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_cell) &&
                                           $stable(i_out_kind)))
        else $error("result beat changed while stalled");

    // only reads carry a cell value
    a_cell_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind != KIND_READ)) |-> (i_out_cell == CELL_EMPTY))
        else $error("nonzero cell_type on a non-read result");

    a_cell_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_cell != CELL_ILLEGAL))
        else $error("illegal cell code on output");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item taken while previous one in work");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && !i_in_ready))
        else $error("activity right after reset");

endmodule

bind falling_sand_grid_engine_unit fsg_checker u_fsg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_cell  (o_out.cell_type),
    .i_out_kind  (o_out.done_kind)
);
